@@ hw/rtl/pssq_pkg.sv @@
// Shared types, codes and field layout of the point set spatial query block.
package pssq_pkg;

  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam int unsigned COORD_BITS_DEF = 16;

  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned DIST_W   = 34;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned IN_TDATA_W  = 144;
  localparam int unsigned IN_RSQ_LSB  = 6 * FIELD_W;
  localparam int unsigned IN_FAC_LSB  = IN_RSQ_LSB + DIST_W;
  localparam int unsigned IN_EIDX_LSB = IN_FAC_LSB + 2;

  localparam int unsigned OUT_TDATA_W = 144;
  localparam int unsigned OUT_USED_W  = IDX_W + 1 + DIST_W + 6 * FIELD_W;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT         = 3'd0,
    OP_SET_FACING     = 3'd1,
    OP_BOUNDS         = 3'd2,
    OP_IN_BOX         = 3'd3,
    OP_IN_SPHERE      = 3'd4,
    OP_FACED_TOWARD   = 3'd5,
    OP_FACING_TOWARD  = 3'd6,
    OP_DISTANCE       = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    DIR_NORTH = 2'd0,
    DIR_EAST  = 2'd1,
    DIR_SOUTH = 2'd2,
    DIR_WEST  = 2'd3
  } dir_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_EXEC  = 2'd1,
    ST_SCAN  = 2'd2,
    ST_DRAIN = 2'd3
  } state_e;

  typedef struct packed {
    op_e  op;
    dir_e facing;
  } pssq_ctl_t;

  typedef struct packed {
    logic [FIELD_W-1:0] min_z;
    logic [FIELD_W-1:0] min_y;
    logic [FIELD_W-1:0] min_x;
    logic [FIELD_W-1:0] max_z;
    logic [FIELD_W-1:0] max_y;
    logic [FIELD_W-1:0] max_x;
  } pssq_bbox_t;

endpackage

@@ hw/rtl/pssq_point_eval.sv @@
// Per-point test unit: squares and compares registered, then sum and final hit.
module pssq_point_eval import pssq_pkg::*; #(
  parameter int unsigned COORD_W = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  pssq_ctl_t            ctl_i,
  input  logic [3*COORD_W-1:0] pt_i,
  input  dir_e                 pt_facing_i,
  input  logic [3*COORD_W-1:0] qa_i,
  input  logic [3*COORD_W-1:0] qb_i,
  input  logic [DIST_W-1:0]    rsq_i,
  output logic [DIST_W-1:0]    dist_o,
  output logic                 hit_o
);

  localparam int unsigned SQ_W  = 2 * COORD_W;
  localparam int unsigned SUM_W = SQ_W + 2;

  logic [COORD_W-1:0] diff [3];
  logic [SQ_W-1:0]    sq_d [3];
  logic [SQ_W-1:0]    sq_q [3];
  logic [2:0]         ge, le, inb;
  logic               hit_pre_d, hit_pre_q;
  logic               sphere_d, sphere_q;
  logic               dist_en_d, dist_en_q;
  logic [SUM_W-1:0]   sum;
  logic [DIST_W-1:0]  sum_ext;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ge[c]   = pt_i[c*COORD_W +: COORD_W] >= qa_i[c*COORD_W +: COORD_W];
      le[c]   = pt_i[c*COORD_W +: COORD_W] <= qa_i[c*COORD_W +: COORD_W];
      inb[c]  = ge[c] && (pt_i[c*COORD_W +: COORD_W] <= qb_i[c*COORD_W +: COORD_W]);
      diff[c] = ge[c] ? pt_i[c*COORD_W +: COORD_W] - qa_i[c*COORD_W +: COORD_W]
                      : qa_i[c*COORD_W +: COORD_W] - pt_i[c*COORD_W +: COORD_W];
      sq_d[c] = SQ_W'(diff[c]) * SQ_W'(diff[c]);
    end
  end

  // Select the test; index 0 is x, index 1 is y.
  always_comb begin
    hit_pre_d = 1'b0;
    case (ctl_i.op)
      OP_IN_BOX: hit_pre_d = &inb;
      OP_FACED_TOWARD: begin
        case (ctl_i.facing)
          DIR_NORTH: hit_pre_d = le[1];
          DIR_EAST:  hit_pre_d = ge[0];
          DIR_SOUTH: hit_pre_d = ge[1];
          DIR_WEST:  hit_pre_d = le[0];
          default:   hit_pre_d = 1'b0;
        endcase
      end
      OP_FACING_TOWARD: begin
        case (pt_facing_i)
          DIR_NORTH: hit_pre_d = ge[1];
          DIR_EAST:  hit_pre_d = le[0];
          DIR_SOUTH: hit_pre_d = le[1];
          DIR_WEST:  hit_pre_d = ge[0];
          default:   hit_pre_d = 1'b0;
        endcase
      end
      default: hit_pre_d = 1'b0;
    endcase
    sphere_d  = ctl_i.op == OP_IN_SPHERE;
    dist_en_d = (ctl_i.op == OP_IN_SPHERE) || (ctl_i.op == OP_DISTANCE);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        sq_q[c] <= sq_d[c];
      end
      hit_pre_q <= hit_pre_d;
      sphere_q  <= sphere_d;
      dist_en_q <= dist_en_d;
    end
  end

  assign sum     = SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
  assign sum_ext = DIST_W'(sum);
  assign dist_o  = dist_en_q ? sum_ext : '0;
  assign hit_o   = sphere_q ? (sum_ext <= rsq_i) : hit_pre_q;

endmodule

@@ hw/rtl/point_set_spatial_query.sv @@
// Top level of the point set spatial query block: stores, sequencer and result register.
//
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tuser: opcode; tdata: query or point fields
// m_axis    out  m_axis_tvalid/tready      tuser: status; tlast: last; tdata: result fields
//
// Insert, set facing and queries on an empty set give their single result through
// the EXEC state and the result register. A query over n stored points reads one
// point per cycle unless the output stalls, the rate set by the single read port of
// the point memory, and streams a result per point (bounds gives just one). No new
// input is taken until the scan drains. A stalled output freezes the whole read pipeline.
// Reset empties the point store and returns every facing to north at once.
module point_set_spatial_query import pssq_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // ax, ay, az, bx, by, bz (16 each), radius_sq (34), facing (2), entry_index (6), pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // opcode (3)
  input  logic [OP_W-1:0]        s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // point_index (6), hit (1), dist_sq (34), max_x, max_y, max_z, min_x, min_y, min_z
  // (16 each), pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // status (2)
  output logic [STATUS_W-1:0]    m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  // Coordinates arrive in 16-bit fields; only the low COORD_BITS of them (at most 16) count.
  localparam int unsigned CW    = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int unsigned AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned PT_W  = 3 * CW;

  state_e                state_q, state_d;
  op_e                   op_q;
  logic [PT_W-1:0]       qa_q, qb_q;
  logic [DIST_W-1:0]     rsq_q;
  dir_e                  fac_q;
  logic [IDX_W-1:0]      eidx_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      rd_idx_q, rd_idx_d;

  // Point memory and facing memory, one synchronous read port each.
  logic [PT_W-1:0]       pt_mem_q  [MAX_POINTS];
  dir_e                  fac_mem_q [MAX_POINTS];
  logic [MAX_POINTS-1:0] fac_valid_q;
  logic [PT_W-1:0]       rd_pt_q;
  dir_e                  rd_fac_q;
  logic                  rd_fv_q;
  dir_e                  pt_facing;

  // Pipeline tags: stage 1 is memory data, stage 2 is the eval register.
  logic                  s1_v_q, s1_last_q, s2_v_q, s2_last_q;
  logic [AW-1:0]         s1_idx_q, s2_idx_q;
  logic [CW-1:0]         acc_max_q [3];
  logic [CW-1:0]         acc_min_q [3];

  logic                  out_v_q;
  logic [IDX_W-1:0]      out_idx_q;
  logic                  out_hit_q;
  logic [DIST_W-1:0]     out_dist_q;
  pssq_bbox_t            out_bbox_q;
  logic                  out_last_q;
  status_e               out_status_q;

  logic                  in_fire, adv;
  logic                  is_query, empty, full, range_err;
  logic                  exec_single, scan_start, issue, issue_last;
  logic                  insert_wr, fac_wr;
  logic                  out_load_scan;
  logic [IDX_W-1:0]      single_idx;
  status_e               single_status;
  pssq_bbox_t            scan_bbox;
  pssq_ctl_t             eval_ctl;
  logic [DIST_W-1:0]     eval_dist;
  logic                  eval_hit;

  // The pipeline moves whenever the result register is free or being emptied.
  assign adv      = !out_v_q || m_axis_tready_i;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign is_query = (op_q != OP_INSERT) && (op_q != OP_SET_FACING);
  assign empty    = count_q == '0;
  assign full     = count_q >= CNT_W'(MAX_POINTS);
  assign range_err  = {1'b0, eidx_q} >= (IDX_W + 1)'(MAX_POINTS);
  assign issue_last = (rd_idx_q + CNT_W'(1)) == count_q;

  // Sequencer outputs.
  always_comb begin
    s_axis_tready_o = 1'b0;
    exec_single     = 1'b0;
    scan_start      = 1'b0;
    issue           = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready_o = 1'b1;
      ST_EXEC: begin
        exec_single = adv && (!is_query || empty);
        scan_start  = is_query && !empty;
      end
      ST_SCAN:  issue = adv;
      ST_DRAIN: ;
      default: ;
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_EXEC;
      ST_EXEC: begin
        if (scan_start) begin
          state_d = ST_SCAN;
        end else if (exec_single) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN:  if (issue && issue_last) state_d = ST_DRAIN;
      ST_DRAIN: if (!s1_v_q && !s2_v_q) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign insert_wr = exec_single && (op_q == OP_INSERT) && !full;
  assign fac_wr    = exec_single && (op_q == OP_SET_FACING) && !range_err;

  always_comb begin
    count_d  = count_q;
    rd_idx_d = rd_idx_q;
    if (insert_wr) count_d = count_q + CNT_W'(1);
    if (scan_start) begin
      rd_idx_d = '0;
    end else if (issue) begin
      rd_idx_d = rd_idx_q + CNT_W'(1);
    end
  end

  // Single-result outcome of insert, set facing and a query on an empty set.
  always_comb begin
    single_idx    = '0;
    single_status = STATUS_OK;
    case (op_q)
      OP_INSERT: begin
        if (full) begin
          single_status = STATUS_FULL;
        end else begin
          single_idx = IDX_W'(count_q);
        end
      end
      OP_SET_FACING: begin
        single_idx    = eidx_q;
        single_status = range_err ? STATUS_RANGE : STATUS_OK;
      end
      default: single_status = STATUS_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      fac_valid_q <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
      if (fac_wr) fac_valid_q[eidx_q[AW-1:0]] <= 1'b1;
      if (adv) begin
        s1_v_q <= issue;
        s2_v_q <= s1_v_q;
      end
      if (exec_single || out_load_scan) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Capture the query at the input transfer.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= op_e'(s_axis_tuser_i);
      for (int c = 0; c < 3; c++) begin
        qa_q[c*CW +: CW] <= s_axis_tdata_i[c*FIELD_W +: CW];
        qb_q[c*CW +: CW] <= s_axis_tdata_i[(c+3)*FIELD_W +: CW];
      end
      rsq_q  <= s_axis_tdata_i[IN_RSQ_LSB +: DIST_W];
      fac_q  <= dir_e'(s_axis_tdata_i[IN_FAC_LSB +: 2]);
      eidx_q <= s_axis_tdata_i[IN_EIDX_LSB +: IDX_W];
    end
  end

  // Point memory: write on insert, read one entry per issue.
  always_ff @(posedge clk_i) begin
    if (insert_wr) pt_mem_q[count_q[AW-1:0]] <= qa_q;
    if (issue) rd_pt_q <= pt_mem_q[rd_idx_q[AW-1:0]];
  end

  // Facing memory; an entry never written reads as north through its valid bit.
  always_ff @(posedge clk_i) begin
    if (fac_wr) fac_mem_q[eidx_q[AW-1:0]] <= fac_q;
    if (issue) begin
      rd_fac_q <= fac_mem_q[rd_idx_q[AW-1:0]];
      rd_fv_q  <= fac_valid_q[rd_idx_q[AW-1:0]];
    end
  end

  assign pt_facing = rd_fv_q ? rd_fac_q : DIR_NORTH;

  // Pipeline tags and the running bounding box.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_idx_q  <= rd_idx_q[AW-1:0];
      s1_last_q <= issue_last;
    end
    if (adv) begin
      s2_idx_q  <= s1_idx_q;
      s2_last_q <= s1_last_q;
      if (s1_v_q) begin
        for (int c = 0; c < 3; c++) begin
          if (s1_idx_q == '0 || rd_pt_q[c*CW +: CW] > acc_max_q[c]) begin
            acc_max_q[c] <= rd_pt_q[c*CW +: CW];
          end
          if (s1_idx_q == '0 || rd_pt_q[c*CW +: CW] < acc_min_q[c]) begin
            acc_min_q[c] <= rd_pt_q[c*CW +: CW];
          end
        end
      end
    end
  end

  assign eval_ctl = '{op: op_q, facing: fac_q};

  pssq_point_eval #(
    .COORD_W (CW)
  ) u_eval (
    .clk_i       (clk_i),
    .en_i        (adv),
    .ctl_i       (eval_ctl),
    .pt_i        (rd_pt_q),
    .pt_facing_i (pt_facing),
    .qa_i        (qa_q),
    .qb_i        (qb_q),
    .rsq_i       (rsq_q),
    .dist_o      (eval_dist),
    .hit_o       (eval_hit)
  );

  // Bounds emits only once, with the last point folded in.
  assign out_load_scan = adv && s2_v_q && ((op_q != OP_BOUNDS) || s2_last_q);

  always_comb begin
    scan_bbox = '0;
    if (op_q == OP_BOUNDS) begin
      scan_bbox.max_x = FIELD_W'(acc_max_q[0]);
      scan_bbox.max_y = FIELD_W'(acc_max_q[1]);
      scan_bbox.max_z = FIELD_W'(acc_max_q[2]);
      scan_bbox.min_x = FIELD_W'(acc_min_q[0]);
      scan_bbox.min_y = FIELD_W'(acc_min_q[1]);
      scan_bbox.min_z = FIELD_W'(acc_min_q[2]);
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (exec_single) begin
      out_idx_q    <= single_idx;
      out_hit_q    <= 1'b0;
      out_dist_q   <= '0;
      out_bbox_q   <= '0;
      out_last_q   <= 1'b1;
      out_status_q <= single_status;
    end else if (out_load_scan) begin
      out_idx_q    <= (op_q == OP_BOUNDS) ? '0 : IDX_W'(s2_idx_q);
      out_hit_q    <= eval_hit;
      out_dist_q   <= eval_dist;
      out_bbox_q   <= scan_bbox;
      out_last_q   <= s2_last_q;
      out_status_q <= STATUS_OK;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, out_bbox_q, out_dist_q, out_hit_q, out_idx_q};
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
